/* rtl/swmd_pkg.sv */
// ----------------------------------------------------------------------------
// swmd_pkg
// Shared types and constants for the LIFO stack with match-delete.
// ----------------------------------------------------------------------------
package swmd_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int WORD_W        = 32;
  localparam int CNT_OUT_W     = 8;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [WORD_W-1:0]  operand;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  read_value;
    status_t                   status;
    logic [CNT_OUT_W-1:0]      occupancy;
    logic [CNT_OUT_W-1:0]      removed_count;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic walk;
    logic out_load;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic walk_last;
  } ctl_stat_t;

endpackage

/* rtl/stack_with_match_delete.sv */
// ----------------------------------------------------------------------------
// stack_with_match_delete
// Bounded LIFO of signed 32-bit words with push, pop, peek and delete-all.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one request word {cmd, operand};
// the result channel out_valid/out_ready returns exactly one word per
// request {read_value, status, occupancy, removed_count}.
// One request is handled at a time; in_ready is high only while idle.
// Push, pop and peek make their single store access, then register the
// result. Delete walks the store from bottom to top at one entry per cycle,
// compacting in place.
// The next request is accepted the cycle after the result is registered,
// even if the receiver has not yet taken it; a request then waits in its
// final step until the result register is free.
// Reset (rst_n low, synchronous) empties the stack and drops any pending
// result; store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module stack_with_match_delete #(
  parameter int DEPTH = swmd_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  swmd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output swmd_pkg::out_word_t out_data
);
  import swmd_pkg::*;

  ctl_cmd_t  ctl;
  ctl_stat_t stat;

  swmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  swmd_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .ctl      (ctl),
    .stat     (stat)
  );

endmodule

/* rtl/swmd_ctrl.sv */
// ----------------------------------------------------------------------------
// swmd_ctrl
// Sequencer: accepts a word, runs the command, then hands the result over.
// ----------------------------------------------------------------------------
module swmd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  swmd_pkg::ctl_stat_t stat,
  output swmd_pkg::ctl_cmd_t  ctl
);
  import swmd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WALK = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        if (stat.cmd == CMD_DELETE && !stat.empty) begin
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_WALK: begin
        ctl.walk = 1'b1;
        if (stat.walk_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/swmd_dpath.sv */
// ----------------------------------------------------------------------------
// swmd_dpath
// Entry store, fill count, compaction pointers and result register.
// ----------------------------------------------------------------------------
module swmd_dpath #(
  parameter int DEPTH = swmd_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swmd_pkg::in_word_t  in_data,
  output swmd_pkg::out_word_t out_data,
  input  swmd_pkg::ctl_cmd_t  ctl,
  output swmd_pkg::ctl_stat_t stat
);
  import swmd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  cmd_t              cmd_r;
  logic [WORD_W-1:0] key_r;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     ri_r, ri_nxt;
  logic [CW-1:0]     wi_r, wi_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  status_t           st_r, st_nxt;
  out_word_t         out_r;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata;
  logic [CW-1:0]     fill_dec;
  logic              full, empty, walk_last, match;
  logic [CW+CNT_OUT_W-1:0] occ_ext, rem_ext;

  assign full      = (fill_r == FULL_CNT);
  assign empty     = (fill_r == '0);
  assign fill_dec  = fill_r - 1'b1;
  assign walk_last = (ri_r == fill_r);
  assign match     = (rdata_r == key_r);

  always_comb begin
    fill_nxt = fill_r;
    ri_nxt   = ri_r;
    wi_nxt   = wi_r;
    rem_nxt  = rem_r;
    st_nxt   = st_r;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = fill_r[AW-1:0];
    raddr    = fill_dec[AW-1:0];
    wdata    = key_r;
    if (ctl.load) begin
      rem_nxt = '0;
    end
    if (ctl.exec) begin
      st_nxt = ST_OK;
      unique case (cmd_r) inside
        CMD_PUSH: begin
          if (full) begin
            st_nxt = ST_FULL;
          end else begin
            we       = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
        end
        CMD_POP, CMD_PEEK: begin
          if (empty) begin
            st_nxt = ST_EMPTY;
          end else begin
            re = 1'b1;
            if (cmd_r == CMD_POP) begin
              fill_nxt = fill_dec;
            end
          end
        end
        default: begin
          // delete: prime the read of the bottom entry
          if (!empty) begin
            re     = 1'b1;
            raddr  = '0;
            ri_nxt = CW'(1);
            wi_nxt = '0;
          end
        end
      endcase
    end
    if (ctl.walk) begin
      // rdata_r holds entry ri_r-1
      waddr = wi_r[AW-1:0];
      wdata = rdata_r;
      if (match) begin
        rem_nxt = rem_r + 1'b1;
      end else begin
        we     = 1'b1;
        wi_nxt = wi_r + 1'b1;
      end
      if (walk_last) begin
        fill_nxt = match ? wi_r : wi_r + 1'b1;
      end else begin
        re     = 1'b1;
        raddr  = ri_r[AW-1:0];
        ri_nxt = ri_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign occ_ext = {{CNT_OUT_W{1'b0}}, fill_r};
  assign rem_ext = {{CNT_OUT_W{1'b0}}, rem_r};

  always_ff @(posedge clk) begin
    ri_r  <= ri_nxt;
    wi_r  <= wi_nxt;
    rem_r <= rem_nxt;
    st_r  <= st_nxt;
    if (ctl.load) begin
      cmd_r <= in_data.cmd;
      key_r <= in_data.operand;
    end
    if (ctl.out_load) begin
      out_r.status        <= st_r;
      out_r.occupancy     <= occ_ext[CNT_OUT_W-1:0];
      out_r.removed_count <= rem_ext[CNT_OUT_W-1:0];
      if (st_r == ST_EMPTY) begin
        out_r.read_value <= '1;
      end else if (cmd_r == CMD_POP || cmd_r == CMD_PEEK) begin
        out_r.read_value <= rdata_r;
      end else begin
        out_r.read_value <= '0;
      end
    end
  end

  assign out_data       = out_r;
  assign stat.cmd       = cmd_r;
  assign stat.empty     = empty;
  assign stat.walk_last = walk_last;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count beyond depth");

  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.walk |-> (wi_r < ri_r) && (ri_r <= fill_r))
    else $error("compaction pointers out of order");

  a_walk_sum: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.walk |-> (CW'(wi_r + rem_r) == CW'(ri_r - 1'b1)))
    else $error("kept plus removed does not match entries read");

  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && cmd_r == CMD_PUSH && !full) |=> fill_r == CW'($past(fill_r) + 1'b1))
    else $error("push did not grow the stack");

endmodule
